// ----- design/gxb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package gxb_pkg;

   // field widths of the three channels
   localparam int BYTE_W     = 8;
   localparam int COLOR_W    = 16;
   localparam int OUT_ADDR_W = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // register field widths
   localparam int CFG_DIM_W  = 13;
   localparam int CFG_BASE_W = 20;
   localparam int CFG_SLOT_W = 3;

   // wide enough for a 13-bit size and the clamp value 2^DIM_BITS for DIM_BITS up to 16
   localparam int CLAMP_W = 17;

   // slot walk
   localparam int SLOT_MAX = 8;
   localparam int SLOT_W   = 4;
   localparam logic [SLOT_W-1:0] SLOTS_1BPP = 4'd8;
   localparam logic [SLOT_W-1:0] SLOTS_2BPP = 4'd4;

   // rgb565 channel layout
   localparam logic [4:0] RB_MASK = 5'h1F;
   localparam logic [5:0] G_MASK  = 6'h3F;

   // divide by 3 as multiply by 171 and shift by 9, exact for sums below 256
   localparam logic [15:0] DIV3_MUL   = 16'd171;
   localparam int          DIV3_SHIFT = 9;

   // 2bpp level that writes the foreground color
   localparam logic [1:0] LEVEL_FULL = 2'd3;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FB_ROW_PIXELS    = 3'd0,
      REG_DEST_BASE        = 3'd1,
      REG_RECT_WIDTH       = 3'd2,
      REG_RECT_HEIGHT      = 3'd3,
      REG_FIRST_PIXEL_SLOT = 3'd4,
      REG_TWO_BIT_MODE     = 3'd5,
      REG_FG_COLOR         = 3'd6,
      REG_BG_COLOR         = 3'd7
   } csr_reg_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_PAL  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   // pixel level of one slot, MSB first
   function automatic logic [1:0] slot_level(input logic [BYTE_W-1:0] src,
                                             input logic two,
                                             input logic [2:0] slot);
      logic [BYTE_W-1:0] shifted;
      if (two) begin
         shifted = src >> {2'd3 - slot[1:0], 1'b0};
         return shifted[1:0];
      end else begin
         shifted = src >> (3'd7 - slot);
         return {1'b0, shifted[0]};
      end
   endfunction

endpackage
`default_nettype wire

// ----- design/gxb_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// glyph byte channel
interface gxb_req_if import gxb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] src_byte;
   modport source (output valid, output src_byte, input ready);
   modport sink (input valid, input src_byte, output ready);
endinterface

// pixel write channel
interface gxb_rsp_if import gxb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [OUT_ADDR_W-1:0] pixel_address;
   logic [COLOR_W-1:0]    pixel_color;
   logic                  last_of_byte;
   modport source (output valid, output pixel_address, output pixel_color,
                   output last_of_byte, input ready);
   modport sink (input valid, input pixel_address, input pixel_color,
                 input last_of_byte, output ready);
endinterface

// register write channel
interface gxb_csr_if import gxb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- design/gxb_blend.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gxb_blend import gxb_pkg::*; (
   input  wire logic [COLOR_W-1:0] fg,
   input  wire logic [COLOR_W-1:0] bg,
   input  wire logic               hi_weight,
   output logic      [COLOR_W-1:0] color
);

   // (2f+b)/3 or (f+2b)/3 on one channel, truncating
   function automatic logic [5:0] mix(input logic [5:0] f, input logic [5:0] b,
                                      input logic hi);
      logic [7:0]  sum;
      logic [15:0] prod;
      if (hi) begin
         sum = (8'(f) << 1) + 8'(b);
      end else begin
         sum = 8'(f) + (8'(b) << 1);
      end
      prod = 16'(sum) * DIV3_MUL;
      return prod[DIV3_SHIFT +: 6];
   endfunction

   logic [5:0] r_mix;
   logic [5:0] g_mix;
   logic [5:0] b_mix;

   // per channel blend, 5/6/5
   always_comb begin
      r_mix = mix({1'b0, fg[15:11] & RB_MASK}, {1'b0, bg[15:11] & RB_MASK}, hi_weight);
      g_mix = mix(fg[10:5] & G_MASK, bg[10:5] & G_MASK, hi_weight);
      b_mix = mix({1'b0, fg[4:0] & RB_MASK}, {1'b0, bg[4:0] & RB_MASK}, hi_weight);
      color = {r_mix[4:0], g_mix, b_mix[4:0]};
   end

endmodule
`default_nettype wire

// ----- design/glyph_expand_blitter_core.sv -----
// a pixel write is registered as its slot is walked and shows on rsp in the next cycle;
// after the byte beat the walker goes to ST_EMIT, or at the start of a rectangle first
// through ST_PAL while the blend unit fills the two palette entries
// throughput: one pixel slot per cycle while rsp is free, from the start slot to the last
// set pixel; a new byte is taken only once the walker is back in ST_IDLE
// reset: synchronous, control registers return to reset values and the walker goes idle
`timescale 1ns / 1ps
`default_nettype none
module glyph_expand_blitter_core import gxb_pkg::*; #(
   parameter int ADDR_BITS = 20,
   parameter int DIM_BITS  = 12
) (
   input wire logic  clock,
   input wire logic  reset,
   gxb_req_if.sink   req_if,
   gxb_rsp_if.source rsp_if,
   gxb_csr_if.sink   csr_if
);

   localparam int CW    = DIM_BITS + 1;
   localparam int PW    = (ADDR_BITS > CFG_DIM_W) ? ADDR_BITS : CFG_DIM_W;
   localparam int BW    = (ADDR_BITS > CFG_BASE_W) ? ADDR_BITS : CFG_BASE_W;
   localparam int OUT_W = (ADDR_BITS < OUT_ADDR_W) ? ADDR_BITS : OUT_ADDR_W;

   // clamp a size register to 1..2^DIM_BITS
   function automatic logic [CW-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
      logic [CLAMP_W-1:0] ext;
      logic [CLAMP_W-1:0] top;
      ext = CLAMP_W'(v);
      top = CLAMP_W'(1) << DIM_BITS;
      if (ext == '0) begin
         ext = CLAMP_W'(1);
      end else if (ext > top) begin
         ext = top;
      end
      return ext[CW-1:0];
   endfunction

   // configuration registers
   logic [CFG_DIM_W-1:0]  fb_row_pixels_ff, fb_row_pixels_in;
   logic [CFG_BASE_W-1:0] dest_base_ff, dest_base_in;
   logic [CFG_DIM_W-1:0]  rect_width_ff, rect_width_in;
   logic [CFG_DIM_W-1:0]  rect_height_ff, rect_height_in;
   logic [CFG_SLOT_W-1:0] first_slot_ff, first_slot_in;
   logic                  two_mode_ff, two_mode_in;
   logic [COLOR_W-1:0]    fg_color_ff, fg_color_in;
   logic [COLOR_W-1:0]    bg_color_ff, bg_color_in;

   // walker state
   state_type             state_ff, state_in;
   logic [DIM_BITS-1:0]   col_ff, col_in;
   logic [DIM_BITS-1:0]   row_ff, row_in;
   logic [ADDR_BITS-1:0]  row_start_ff, row_start_in;
   logic [ADDR_BITS-1:0]  col_addr_ff, col_addr_in;
   logic                  pal_idx_ff, pal_idx_in;
   logic [2:0]            slot_ff, slot_in;
   logic [SLOT_MAX-1:0]   mask_ff, mask_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload
   logic [BYTE_W-1:0]     byte_ff, byte_in;
   logic                  two_ff, two_in;
   logic [ADDR_BITS-1:0]  walk_addr_ff, walk_addr_in;
   logic [COLOR_W-1:0]    pal_ff [2];
   logic [COLOR_W-1:0]    pal_wr_data;
   logic                  pal_wr;
   logic [ADDR_BITS-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [COLOR_W-1:0]    rsp_color_ff, rsp_color_in;
   logic                  rsp_last_ff, rsp_last_in;

   // per-byte setup
   logic                  req_beat;
   logic                  blit_start;
   logic [CW-1:0]         w_dim, h_dim, col_ext, rem, row_inc;
   logic [SLOT_W-1:0]     slots, start_slot, avail;
   logic                  row_done;
   logic [SLOT_MAX-1:0]   new_mask;
   logic [ADDR_BITS-1:0]  dest_a, pitch_a, base_a, rs_a, next_row_a;
   logic [SLOT_W-1:0]     pv;

   // emit step
   logic                  out_free;
   logic [1:0]            cur_level;
   logic [SLOT_MAX-1:0]   rest_mask;
   logic [COLOR_W-1:0]    blend_color;
   logic [OUT_ADDR_W-1:0] out_addr;

   // shared blend unit, one palette entry per cycle
   gxb_blend u_blend (
      .fg        (fg_color_ff),
      .bg        (bg_color_ff),
      .hi_weight (pal_idx_ff),
      .color     (blend_color)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign req_beat     = req_if.valid && (state_ff == ST_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   // register writes
   always_comb begin
      fb_row_pixels_in = fb_row_pixels_ff;
      dest_base_in     = dest_base_ff;
      rect_width_in    = rect_width_ff;
      rect_height_in   = rect_height_ff;
      first_slot_in    = first_slot_ff;
      two_mode_in      = two_mode_ff;
      fg_color_in      = fg_color_ff;
      bg_color_in      = bg_color_ff;
      if (csr_if.valid) begin
         unique case (csr_reg_type'(csr_if.index))
            REG_FB_ROW_PIXELS:    fb_row_pixels_in = csr_if.data[CFG_DIM_W-1:0];
            REG_DEST_BASE:        dest_base_in     = csr_if.data[CFG_BASE_W-1:0];
            REG_RECT_WIDTH:       rect_width_in    = csr_if.data[CFG_DIM_W-1:0];
            REG_RECT_HEIGHT:      rect_height_in   = csr_if.data[CFG_DIM_W-1:0];
            REG_FIRST_PIXEL_SLOT: first_slot_in    = csr_if.data[CFG_SLOT_W-1:0];
            REG_TWO_BIT_MODE:     two_mode_in      = csr_if.data[0];
            REG_FG_COLOR:         fg_color_in      = csr_if.data[COLOR_W-1:0];
            REG_BG_COLOR:         bg_color_in      = csr_if.data[COLOR_W-1:0];
         endcase
      end
   end

   // row window, slot range and addresses of the incoming byte
   always_comb begin
      blit_start = (col_ff == '0) && (row_ff == '0);
      w_dim      = clamp_dim(rect_width_ff);
      h_dim      = clamp_dim(rect_height_ff);
      slots      = two_mode_ff ? SLOTS_2BPP : SLOTS_1BPP;
      if (col_ff != '0) begin
         start_slot = '0;
      end else if (two_mode_ff) begin
         start_slot = {2'b00, first_slot_ff[1:0]};
      end else begin
         start_slot = {1'b0, first_slot_ff};
      end
      avail   = slots - start_slot;
      col_ext = {1'b0, col_ff};
      // a shrunken width still consumes one pixel before closing the row
      rem      = (col_ext >= w_dim) ? CW'(1) : (w_dim - col_ext);
      row_done = (rem <= CW'(avail));
      row_inc  = {1'b0, row_ff} + CW'(1);

      for (int p = 0; p < SLOT_MAX; p++) begin
         pv = SLOT_W'(p);
         new_mask[p] = (pv >= start_slot) && (pv < slots) &&
                       (CW'(pv - start_slot) < rem) &&
                       (slot_level(req_if.src_byte, two_mode_ff, 3'(p)) != 2'd0);
      end

      dest_a     = ADDR_BITS'(BW'(dest_base_ff));
      pitch_a    = ADDR_BITS'(PW'(fb_row_pixels_ff));
      base_a     = blit_start ? dest_a : col_addr_ff;
      rs_a       = blit_start ? dest_a : row_start_ff;
      next_row_a = rs_a + pitch_a;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      row_start_in = row_start_ff;
      col_addr_in  = col_addr_ff;
      pal_idx_in   = pal_idx_ff;
      slot_in      = slot_ff;
      mask_in      = mask_ff;
      byte_in      = byte_ff;
      two_in       = two_ff;
      walk_addr_in = walk_addr_ff;
      pal_wr       = 1'b0;
      pal_wr_data  = blend_color;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      cur_level    = slot_level(byte_ff, two_ff, slot_ff);
      rest_mask    = mask_ff >> ({1'b0, slot_ff} + SLOT_W'(1));

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               byte_in      = req_if.src_byte;
               two_in       = two_mode_ff;
               mask_in      = new_mask;
               slot_in      = start_slot[2:0];
               walk_addr_in = base_a;
               pal_idx_in   = 1'b0;
               row_start_in = row_done ? next_row_a : rs_a;
               col_addr_in  = row_done ? next_row_a : (base_a + ADDR_BITS'(avail));
               if (row_done) begin
                  col_in = '0;
                  row_in = (row_inc >= h_dim) ? '0 : row_inc[DIM_BITS-1:0];
               end else begin
                  col_in = DIM_BITS'(col_ext + CW'(avail));
               end
               if (blit_start) begin
                  state_in = ST_PAL;
               end else if (new_mask != '0) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_PAL: begin
            pal_wr     = 1'b1;
            pal_idx_in = 1'b1;
            if (pal_idx_ff) begin
               state_in = (mask_ff != '0) ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               if (mask_ff[slot_ff]) begin
                  rsp_valid_in = 1'b1;
                  rsp_addr_in  = walk_addr_ff;
                  rsp_last_in  = (rest_mask == '0);
                  if (two_ff && (cur_level != LEVEL_FULL)) begin
                     rsp_color_in = pal_ff[cur_level[1]];
                  end else begin
                     rsp_color_in = fg_color_ff;
                  end
               end
               slot_in      = slot_ff + 3'd1;
               walk_addr_in = walk_addr_ff + ADDR_BITS'(1);
               if (rest_mask == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fb_row_pixels_ff <= CFG_DIM_W'(320);
         dest_base_ff     <= '0;
         rect_width_ff    <= CFG_DIM_W'(1);
         rect_height_ff   <= CFG_DIM_W'(1);
         first_slot_ff    <= '0;
         two_mode_ff      <= 1'b0;
         fg_color_ff      <= '1;
         bg_color_ff      <= '0;
         state_ff         <= ST_IDLE;
         col_ff           <= '0;
         row_ff           <= '0;
         row_start_ff     <= '0;
         col_addr_ff      <= '0;
         pal_idx_ff       <= 1'b0;
         slot_ff          <= '0;
         mask_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         fb_row_pixels_ff <= fb_row_pixels_in;
         dest_base_ff     <= dest_base_in;
         rect_width_ff    <= rect_width_in;
         rect_height_ff   <= rect_height_in;
         first_slot_ff    <= first_slot_in;
         two_mode_ff      <= two_mode_in;
         fg_color_ff      <= fg_color_in;
         bg_color_ff      <= bg_color_in;
         state_ff         <= state_in;
         col_ff           <= col_in;
         row_ff           <= row_in;
         row_start_ff     <= row_start_in;
         col_addr_ff      <= col_addr_in;
         pal_idx_ff       <= pal_idx_in;
         slot_ff          <= slot_in;
         mask_ff          <= mask_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      two_ff       <= two_in;
      walk_addr_ff <= walk_addr_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
      if (pal_wr) begin
         pal_ff[pal_idx_ff] <= pal_wr_data;
      end
   end

   // output beat
   always_comb begin
      out_addr            = '0;
      out_addr[OUT_W-1:0] = rsp_addr_ff[OUT_W-1:0];
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.pixel_address = out_addr;
   assign rsp_if.pixel_color   = rsp_color_ff;
   assign rsp_if.last_of_byte  = rsp_last_ff;

endmodule
`default_nettype wire

// ----- design/gxb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gxb_checker import gxb_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [OUT_ADDR_W-1:0] rsp_pixel_address,
   input wire logic [COLOR_W-1:0]    rsp_pixel_color,
   input wire logic                  rsp_last_of_byte
);

   // no pixel beat right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("pixel beat offered right after reset");

   // a stalled pixel beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_address) &&
         $stable(rsp_pixel_color) && $stable(rsp_last_of_byte))
      else $error("stalled pixel beat changed");

   // a byte with pixels still to come blocks the next byte
   a_busy_mid_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_byte |-> !req_ready)
      else $error("byte taken before the previous byte finished");

   // a stalled non-final pixel beat keeps a waiting byte from being taken just after it
   a_no_gap_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_byte && req_valid |=> !(req_valid && req_ready &&
         $past(rsp_valid && !rsp_ready)))
      else $error("byte taken while a non-final pixel stalled");

endmodule

bind glyph_expand_blitter_core gxb_checker u_gxb_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_pixel_address (rsp_if.pixel_address),
   .rsp_pixel_color   (rsp_if.pixel_color),
   .rsp_last_of_byte  (rsp_if.last_of_byte)
);
`default_nettype wire

// ----- tb/tb_glyph_expand_blitter_core.sv -----
`timescale 1ns / 1ps
module tb_glyph_expand_blitter_core;
   import gxb_pkg::*;

   localparam int RANDOM_ITEMS  = 260;
   localparam int QUIET_TAIL    = 60;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DIM_TOP       = 4096;
   localparam int REPORT_LINES  = 40;

   typedef struct packed {
      logic [OUT_ADDR_W-1:0] addr;
      logic [COLOR_W-1:0]    color;
      logic                  last_flag;
   } pixel_write_type;

   logic clock;
   logic reset;

   gxb_req_if req_bus ();
   gxb_rsp_if rsp_bus ();
   gxb_csr_if csr_bus ();

   glyph_expand_blitter_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // register shadow
   logic [CFG_DIM_W-1:0]  cfg_pitch;
   logic [CFG_BASE_W-1:0] cfg_base;
   logic [CFG_DIM_W-1:0]  cfg_width;
   logic [CFG_DIM_W-1:0]  cfg_height;
   logic [CFG_SLOT_W-1:0] cfg_slot;
   logic                  cfg_two;
   logic [COLOR_W-1:0]    cfg_fg;
   logic [COLOR_W-1:0]    cfg_bg;

   // rectangle walk state
   int unsigned           col_pos;
   int unsigned           row_pos;
   logic [OUT_ADDR_W-1:0] row_addr;
   logic [COLOR_W-1:0]    blend_third;
   logic [COLOR_W-1:0]    blend_two_thirds;

   pixel_write_type   pixel_writes[$];
   logic [BYTE_W-1:0] glyph_queue[$];

   bit idling;
   int req_gap;
   int rsp_stall;
   int mismatches = 0;
   int bytes_taken = 0;
   int writes_seen = 0;
   int reg_writes = 0;
   int cycles = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned dim_clamp(input logic [CFG_DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > DIM_TOP) return DIM_TOP;
      return v;
   endfunction

   // per channel (f*num + b*(3-num))/3, truncated
   function automatic logic [COLOR_W-1:0] mix565(input logic [COLOR_W-1:0] f,
                                                 input logic [COLOR_W-1:0] b,
                                                 input int unsigned num);
      int unsigned r;
      int unsigned g;
      int unsigned bl;
      r  = (f[15:11] * num + b[15:11] * (3 - num)) / 3;
      g  = (f[10:5] * num + b[10:5] * (3 - num)) / 3;
      bl = (f[4:0] * num + b[4:0] * (3 - num)) / 3;
      return {r[4:0], g[5:0], bl[4:0]};
   endfunction

   // expected pixel writes of one glyph byte
   function automatic void expand_glyph_byte(input logic [BYTE_W-1:0] src);
      int unsigned     w;
      int unsigned     h;
      int unsigned     slots;
      int unsigned     slot;
      int unsigned     lvl;
      int unsigned     n;
      bit              row_done;
      pixel_write_type wr;
      w = dim_clamp(cfg_width);
      h = dim_clamp(cfg_height);
      slots = cfg_two ? 4 : 8;
      n = 0;
      row_done = 1'b0;
      // blit start latches base and palette
      if (col_pos == 0 && row_pos == 0) begin
         row_addr = cfg_base;
         blend_third = mix565(cfg_fg, cfg_bg, 1);
         blend_two_thirds = mix565(cfg_fg, cfg_bg, 2);
      end
      slot = (col_pos == 0) ? (cfg_slot & (slots - 1)) : 0;
      while (slot < slots && !row_done) begin
         if (cfg_two) lvl = (src >> (6 - 2 * slot)) & 3;
         else lvl = (src >> (7 - slot)) & 1;
         if (lvl != 0) begin
            if (!cfg_two || lvl == 3) wr.color = cfg_fg;
            else if (lvl == 1) wr.color = blend_third;
            else wr.color = blend_two_thirds;
            wr.addr = row_addr + OUT_ADDR_W'(col_pos);
            wr.last_flag = 1'b0;
            pixel_writes.push_back(wr);
            n++;
         end
         col_pos++;
         slot++;
         if (col_pos >= w) row_done = 1'b1;
      end
      // row end drops the rest of the byte
      if (row_done) begin
         col_pos = 0;
         row_pos++;
         row_addr = row_addr + OUT_ADDR_W'(cfg_pitch);
         if (row_pos >= h) row_pos = 0;
      end
      if (n > 0) pixel_writes[pixel_writes.size() - 1].last_flag = 1'b1;
   endfunction

   task automatic report(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LINES) $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // glyph byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.src_byte <= '0;
         req_gap <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_bus.valid <= 1'b0;
         end else if (glyph_queue.size() > 0) begin
            req_bus.valid <= 1'b1;
            req_bus.src_byte <= glyph_queue.pop_front();
            if (idling && $urandom_range(0, 3) == 0) req_gap <= $urandom_range(1, 3);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // pixel write back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_bus.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 4) == 0) begin
         rsp_stall <= $urandom_range(0, 2);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // monitor: register beats, pixel write checks, then glyph prediction
   always @(posedge clock) begin
      pixel_write_type want;
      if (reset) begin
         cfg_pitch = 13'd320;
         cfg_base = '0;
         cfg_width = 13'd1;
         cfg_height = 13'd1;
         cfg_slot = '0;
         cfg_two = 1'b0;
         cfg_fg = 16'hFFFF;
         cfg_bg = 16'h0000;
         col_pos = 0;
         row_pos = 0;
         row_addr = '0;
         pixel_writes.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            reg_writes++;
            case (csr_reg_type'(csr_bus.index))
               REG_FB_ROW_PIXELS:    cfg_pitch = csr_bus.data[CFG_DIM_W-1:0];
               REG_DEST_BASE:        cfg_base = csr_bus.data[CFG_BASE_W-1:0];
               REG_RECT_WIDTH:       cfg_width = csr_bus.data[CFG_DIM_W-1:0];
               REG_RECT_HEIGHT:      cfg_height = csr_bus.data[CFG_DIM_W-1:0];
               REG_FIRST_PIXEL_SLOT: cfg_slot = csr_bus.data[CFG_SLOT_W-1:0];
               REG_TWO_BIT_MODE:     cfg_two = csr_bus.data[0];
               REG_FG_COLOR:         cfg_fg = csr_bus.data[COLOR_W-1:0];
               REG_BG_COLOR:         cfg_bg = csr_bus.data[COLOR_W-1:0];
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            writes_seen++;
            if (pixel_writes.size() == 0) begin
               report($sformatf("unexpected write addr %h color %h last %b",
                                rsp_bus.pixel_address, rsp_bus.pixel_color,
                                rsp_bus.last_of_byte));
            end else begin
               want = pixel_writes.pop_front();
               if (rsp_bus.pixel_address !== want.addr || rsp_bus.pixel_color !== want.color
                   || rsp_bus.last_of_byte !== want.last_flag)
                  report($sformatf("addr %h/%h color %h/%h last %b/%b (got/exp)",
                                   rsp_bus.pixel_address, want.addr, rsp_bus.pixel_color,
                                   want.color, rsp_bus.last_of_byte, want.last_flag));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            bytes_taken++;
            expand_glyph_byte(req_bus.src_byte);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d writes pending", cycles, pixel_writes.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // one register beat
   task automatic write_reg(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic program_regs(input logic [CSR_DATA_W-1:0] pitch, base, width, height,
                               input logic [CSR_DATA_W-1:0] slot, two, fg, bg);
      write_reg(REG_FB_ROW_PIXELS, pitch);
      write_reg(REG_DEST_BASE, base);
      write_reg(REG_RECT_WIDTH, width);
      write_reg(REG_RECT_HEIGHT, height);
      write_reg(REG_FIRST_PIXEL_SLOT, slot);
      write_reg(REG_TWO_BIT_MODE, two);
      write_reg(REG_FG_COLOR, fg);
      write_reg(REG_BG_COLOR, bg);
   endtask

   // all bytes taken, all writes seen, then let a byte without writes finish its walk
   task automatic drain();
      do @(negedge clock);
      while (glyph_queue.size() != 0 || req_bus.valid || pixel_writes.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // close an open rectangle with a one pixel blit
   task automatic finish_rectangle();
      if (col_pos != 0 || row_pos != 0) begin
         write_reg(REG_RECT_WIDTH, CSR_DATA_W'(1));
         write_reg(REG_RECT_HEIGHT, CSR_DATA_W'(1));
         glyph_queue.push_back(8'($urandom));
         drain();
      end
   endtask

   // value in the low bits, sometimes junk above the field
   function automatic logic [CSR_DATA_W-1:0] pad_bits(input int unsigned v,
                                                       input int unsigned keep);
      logic [CSR_DATA_W-1:0] mask;
      logic [CSR_DATA_W-1:0] val;
      mask = (CSR_DATA_W'(1) << keep) - 1'b1;
      val = CSR_DATA_W'(v) & mask;
      if ($urandom_range(0, 3) == 0) val = val | (CSR_DATA_W'($urandom) & ~mask);
      return val;
   endfunction

   // stimulus
   initial begin
      int unsigned w;
      int unsigned h;
      int unsigned s;
      int unsigned two;
      int unsigned slots;
      int unsigned per_row;
      int unsigned rows;
      int unsigned n;
      int unsigned pitch;
      int unsigned density;
      int unsigned taken;
      bit          mid_write;
      logic [BYTE_W-1:0] b;

      csr_bus.valid <= 1'b0;
      csr_bus.index <= REG_FB_ROW_PIXELS;
      csr_bus.data <= '0;
      reset <= 1'b1;
      idling = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset values: one pixel rectangle, second byte restarts it with a clear pixel
      glyph_queue.push_back(8'h80); glyph_queue.push_back(8'h7F);
      drain();

      // zero pitch, base near the top so addresses wrap, start slot 5
      program_regs(20'd0, 20'hFFFFA, 20'd11, 20'd2, 20'd5, 20'd0, 20'hF800, 20'h07E0);
      glyph_queue.push_back(8'hFF); glyph_queue.push_back(8'hFF);
      glyph_queue.push_back(8'hA5); glyph_queue.push_back(8'hFF);
      drain();

      // 2bpp, slot 7 folds to 3, all four levels, row ends inside a byte
      program_regs(20'd4096, 20'h00100, 20'd6, 20'd2, 20'd7, 20'd1, 20'hFFFF, 20'h0000);
      glyph_queue.push_back(8'h03); glyph_queue.push_back(8'hE4);
      glyph_queue.push_back(8'h1B); glyph_queue.push_back(8'h02);
      glyph_queue.push_back(8'hFF); glyph_queue.push_back(8'h40);
      drain();

      // zero width and height act as one
      program_regs(20'd8191, 20'h00040, 20'd0, 20'd0, 20'd3, 20'd0, 20'h1234, 20'hFFFF);
      glyph_queue.push_back(8'h10); glyph_queue.push_back(8'hEF);
      drain();

      // mode, base and colors rewritten in the middle of a row
      program_regs(20'd100, 20'h00200, 20'd20, 20'd2, 20'd0, 20'd0, 20'h001F, 20'hF800);
      glyph_queue.push_back(8'hFF); glyph_queue.push_back(8'h81);
      drain();
      write_reg(REG_TWO_BIT_MODE, CSR_DATA_W'(1));
      write_reg(REG_DEST_BASE, 20'h00500);
      write_reg(REG_BG_COLOR, CSR_DATA_W'(0));
      write_reg(REG_FG_COLOR, 20'hFFE0);
      glyph_queue.push_back(8'h9C); glyph_queue.push_back(8'hFF);
      glyph_queue.push_back(8'h55); glyph_queue.push_back(8'hAA);
      glyph_queue.push_back(8'h00); glyph_queue.push_back(8'hE4);
      glyph_queue.push_back(8'h6C);
      drain();

      // oversized width keeps a long row open across mostly empty bytes
      finish_rectangle();
      program_regs(20'd8191, CSR_DATA_W'($urandom_range(0, 20'hFFFFF)), 20'd8191, 20'd0,
                   20'd0, 20'd0, CSR_DATA_W'($urandom_range(0, 16'hFFFF)),
                   CSR_DATA_W'($urandom_range(0, 16'hFFFF)));
      for (int i = 0; i < 24; i++)
         glyph_queue.push_back((i % 8 == 7) ? 8'($urandom) : 8'h00);

      // random rectangles
      taken = 0;
      while (taken < RANDOM_ITEMS) begin
         if (taken >= RANDOM_ITEMS - QUIET_TAIL) idling = 1'b0;
         drain();
         if ($urandom_range(0, 1) == 1) finish_rectangle();
         w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
         h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
         if ($urandom_range(0, 19) == 0) h = $urandom_range(DIM_TOP + 1, 8191);
         s = $urandom_range(0, 7);
         two = $urandom_range(0, 1);
         case ($urandom_range(0, 3))
            0: pitch = 0;
            1: pitch = $urandom_range(1, 64);
            2: pitch = $urandom_range(65, DIM_TOP);
            default: pitch = $urandom_range(DIM_TOP + 1, 8191);
         endcase
         program_regs(pad_bits(pitch, CFG_DIM_W), pad_bits($urandom, CFG_BASE_W),
                      pad_bits(w, CFG_DIM_W), pad_bits(h, CFG_DIM_W),
                      pad_bits(s, CFG_SLOT_W), pad_bits(two, 1),
                      pad_bits($urandom, COLOR_W), pad_bits($urandom, COLOR_W));

         // whole rows from the start slot, sometimes a byte short or a few over
         slots = two ? 4 : 8;
         per_row = ((s & (slots - 1)) + dim_clamp(13'(w)) + slots - 1) / slots;
         rows = (dim_clamp(13'(h)) > 4) ? 3 : dim_clamp(13'(h));
         n = rows * per_row;
         case ($urandom_range(0, 5))
            0: n = n + $urandom_range(1, 3);
            1: if (n > 1) n = n - 1;
            default: ;
         endcase
         density = $urandom_range(0, 3);
         mid_write = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < n; i++) begin
            if (mid_write && i == n / 2) begin
               drain();
               write_reg(csr_reg_type'($urandom_range(0, 7)),
                         CSR_DATA_W'($urandom_range(0, 20'hFFFFF)));
            end
            case (density)
               0: b = 8'($urandom);
               1: b = 8'($urandom & $urandom);
               2: b = 8'($urandom | $urandom);
               default: b = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            endcase
            glyph_queue.push_back(b);
         end
         taken += n;
      end
      drain();

      $display("%0d glyph bytes in, %0d pixel writes checked, %0d register writes",
               bytes_taken, writes_seen, reg_writes);
      $display("1bpp and 2bpp blits, clamped sizes, address wrap, mid-row register changes");
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- glyph_expand_blitter_core.f -----
design/gxb_pkg.sv
design/gxb_if.sv
design/gxb_blend.sv
design/glyph_expand_blitter_core.sv
design/gxb_checker.sv
tb/tb_glyph_expand_blitter_core.sv
